// ----- rtl/ioc_pkg.sv -----
// Package with the types, constants and helpers of the interval offset cache.
`default_nettype none
package ioc_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = IDX_W + 1;

    localparam logic [39:0] MERGE_WINDOW_RST = 40'(7 * 24 * 60 * 60);
    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

    localparam logic FN_LOOKUP = 1'b0;
    localparam logic FN_UPDATE = 1'b1;

    localparam logic [1:0] ST_MISS   = 2'd0;
    localparam logic [1:0] ST_HIT    = 2'd1;
    localparam logic [1:0] ST_BEFORE = 2'd2;
    localparam logic [1:0] ST_UPDATE = 2'd3;

    localparam logic [1:0] CFG_MERGE_WINDOW    = 2'd0;
    localparam logic [1:0] CFG_EARLIEST_TIME   = 2'd1;
    localparam logic [1:0] CFG_STANDARD_OFFSET = 2'd2;

    typedef struct packed {
        logic        func;
        logic [63:0] time_point;
        logic [47:0] offset_in;
        logic        dst_in;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] offset_out;
        logic        dst_out;
    } out_t;

    typedef struct packed {
        logic [63:0] start_time;
        logic [63:0] end_time;
        logic [47:0] offset;
        logic        dst;
        logic [31:0] stamp;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MATCHP,
        S_MATCHS,
        S_WRITE,
        S_RESP
    } state_t;

    // Flipping the sign bit makes an unsigned compare order signed times.
    function automatic logic [63:0] bias(input logic [63:0] x);
        return x ^ SIGN_BIT;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/interval_offset_cache_lru.sv -----
// Top level of the interval offset cache with least recently touched replacement.
//
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid, in_ready  | in_data  (func, time_point, offset_in, dst_in)
// out     | output    | out_valid, out_ready| out_data (status, offset_out, dst_out)
// cfg     | input     | cfg_we              | cfg_index, cfg_wdata
//
// A lookup before the earliest time goes straight to the result step. Any other
// lookup or update makes one pass over the entry memory, one entry per cycle
// through its single read port, then one decision step for a lookup or a covered
// update or three for any other update, and the result step.
// Reset clears all valid bits and the touch counter at once; no clearing pass.
// A new transaction is taken while an earlier result waits in the output register;
// the block stalls before its own result only if that register is still full.
`default_nettype none
module interval_offset_cache_lru
    import ioc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_t         in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_t             out_data,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata
);

    entry_t mem [ENTRIES];
    entry_t rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic mem_we;
    logic [IDX_W-1:0] mem_wa;
    entry_t mem_wd;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0] pipe_idx_reg, pipe_idx_next;
    in_t req_reg, req_next;
    logic [31:0] touch_reg, touch_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic pred_found_reg, pred_found_next;
    logic [IDX_W-1:0] pred_idx_reg, pred_idx_next;
    entry_t pred_ent_reg, pred_ent_next;
    logic succ_found_reg, succ_found_next;
    logic [IDX_W-1:0] succ_idx_reg, succ_idx_next;
    entry_t succ_ent_reg, succ_ent_next;
    logic vic_found_reg, vic_found_next;
    logic [IDX_W-1:0] vic_idx_reg, vic_idx_next;
    entry_t vic_ent_reg, vic_ent_next;
    logic free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic pmatch_reg, pmatch_next;
    logic smatch_reg, smatch_next;
    out_t res_reg, res_next;
    logic out_valid_reg, out_valid_next;
    out_t out_data_reg, out_data_next;
    logic [39:0] merge_window_reg, merge_window_next;
    logic [63:0] earliest_time_reg, earliest_time_next;
    logic [47:0] std_offset_reg, std_offset_next;

    logic [63:0] tb;
    logic [63:0] sb;
    logic [63:0] eb;
    logic [63:0] gap;
    logic ent_match;
    logic covered;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        pipe_vld_next      = 1'b0;
        pipe_idx_next      = pipe_idx_reg;
        req_next           = req_reg;
        touch_next         = touch_reg;
        valid_next         = valid_reg;
        pred_found_next    = pred_found_reg;
        pred_idx_next      = pred_idx_reg;
        pred_ent_next      = pred_ent_reg;
        succ_found_next    = succ_found_reg;
        succ_idx_next      = succ_idx_reg;
        succ_ent_next      = succ_ent_reg;
        vic_found_next     = vic_found_reg;
        vic_idx_next       = vic_idx_reg;
        vic_ent_next       = vic_ent_reg;
        free_found_next    = free_found_reg;
        free_idx_next      = free_idx_reg;
        pmatch_next        = pmatch_reg;
        smatch_next        = smatch_reg;
        res_next           = res_reg;
        out_valid_next     = out_valid_reg;
        out_data_next      = out_data_reg;
        merge_window_next  = merge_window_reg;
        earliest_time_next = earliest_time_reg;
        std_offset_next    = std_offset_reg;
        rd_addr            = cnt_reg[IDX_W-1:0];
        mem_we             = 1'b0;
        mem_wa             = pred_idx_reg;
        mem_wd             = pred_ent_reg;
        tb                 = bias(req_reg.time_point);
        sb                 = bias(rd_data_reg.start_time);
        eb                 = bias(pred_ent_reg.end_time);
        gap                = 64'd0;
        ent_match          = 1'b0;
        covered            = pred_found_reg && (tb <= eb);

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        if (cfg_we) begin
            unique case (cfg_index)
                CFG_MERGE_WINDOW:    merge_window_next  = cfg_wdata[39:0];
                CFG_EARLIEST_TIME:   earliest_time_next = cfg_wdata;
                CFG_STANDARD_OFFSET: std_offset_next    = cfg_wdata[47:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    req_next        = in_data;
                    res_next        = '0;
                    pred_found_next = 1'b0;
                    succ_found_next = 1'b0;
                    vic_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    pmatch_next     = 1'b0;
                    smatch_next     = 1'b0;
                    cnt_next        = '0;
                    if (in_data.func == FN_LOOKUP &&
                        bias(in_data.time_point) < bias(earliest_time_reg)) begin
                        res_next.status     = ST_BEFORE;
                        res_next.offset_out = std_offset_reg;
                        state_next          = S_RESP;
                    end else begin
                        touch_next = touch_reg + 32'd1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (cnt_reg < CNT_W'(ENTRIES)) begin
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = cnt_reg[IDX_W-1:0];
                    cnt_next      = cnt_reg + 1'b1;
                end
                if (pipe_vld_reg) begin
                    if (valid_reg[pipe_idx_reg]) begin
                        if (sb <= tb && (!pred_found_reg ||
                                         sb > bias(pred_ent_reg.start_time))) begin
                            pred_found_next = 1'b1;
                            pred_idx_next   = pipe_idx_reg;
                            pred_ent_next   = rd_data_reg;
                        end
                        if (sb > tb && (!succ_found_reg ||
                                        sb < bias(succ_ent_reg.start_time))) begin
                            succ_found_next = 1'b1;
                            succ_idx_next   = pipe_idx_reg;
                            succ_ent_next   = rd_data_reg;
                        end
                        if (!vic_found_reg || rd_data_reg.stamp < vic_ent_reg.stamp ||
                            (rd_data_reg.stamp == vic_ent_reg.stamp &&
                             sb < bias(vic_ent_reg.start_time))) begin
                            vic_found_next = 1'b1;
                            vic_idx_next   = pipe_idx_reg;
                            vic_ent_next   = rd_data_reg;
                        end
                    end else if (!free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = pipe_idx_reg;
                    end
                end else if (cnt_reg == CNT_W'(ENTRIES)) begin
                    state_next = S_MATCHP;
                end
            end
            S_MATCHP: begin
                // A covered time only refreshes the stamp, for lookups and updates alike.
                if (covered) begin
                    mem_we       = 1'b1;
                    mem_wa       = pred_idx_reg;
                    mem_wd       = pred_ent_reg;
                    mem_wd.stamp = touch_reg;
                end
                if (req_reg.func == FN_LOOKUP) begin
                    if (covered) begin
                        res_next.status     = ST_HIT;
                        res_next.offset_out = pred_ent_reg.offset;
                        res_next.dst_out    = pred_ent_reg.dst;
                    end
                    state_next = S_RESP;
                end else begin
                    res_next.status = ST_UPDATE;
                    if (covered) begin
                        state_next = S_RESP;
                    end else begin
                        gap         = tb - eb;
                        ent_match   = pred_ent_reg.offset == req_reg.offset_in &&
                                      pred_ent_reg.dst == req_reg.dst_in;
                        pmatch_next = pred_found_reg && ent_match &&
                                      gap <= {24'd0, merge_window_reg};
                        state_next  = S_MATCHS;
                    end
                end
            end
            S_MATCHS: begin
                gap         = bias(succ_ent_reg.start_time) - tb;
                ent_match   = succ_ent_reg.offset == req_reg.offset_in &&
                              succ_ent_reg.dst == req_reg.dst_in;
                smatch_next = succ_found_reg && ent_match &&
                              gap <= {24'd0, merge_window_reg};
                state_next  = S_WRITE;
            end
            S_WRITE: begin
                mem_we = 1'b1;
                priority if (pmatch_reg && smatch_reg) begin
                    mem_wa          = pred_idx_reg;
                    mem_wd          = pred_ent_reg;
                    mem_wd.end_time = succ_ent_reg.end_time;
                    mem_wd.stamp    = touch_reg;
                    valid_next[succ_idx_reg] = 1'b0;
                end else if (pmatch_reg) begin
                    mem_wa          = pred_idx_reg;
                    mem_wd          = pred_ent_reg;
                    mem_wd.end_time = req_reg.time_point;
                    mem_wd.stamp    = touch_reg;
                end else if (smatch_reg) begin
                    mem_wa            = succ_idx_reg;
                    mem_wd            = succ_ent_reg;
                    mem_wd.start_time = req_reg.time_point;
                    mem_wd.stamp      = touch_reg;
                end else begin
                    mem_wa            = free_found_reg ? free_idx_reg : vic_idx_reg;
                    mem_wd.start_time = req_reg.time_point;
                    mem_wd.end_time   = req_reg.time_point;
                    mem_wd.offset     = req_reg.offset_in;
                    mem_wd.dst        = req_reg.dst_in;
                    mem_wd.stamp      = touch_reg;
                    valid_next[mem_wa] = 1'b1;
                end
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg         <= S_IDLE;
            cnt_reg           <= '0;
            pipe_vld_reg      <= 1'b0;
            touch_reg         <= '0;
            valid_reg         <= '0;
            out_valid_reg     <= 1'b0;
            merge_window_reg  <= MERGE_WINDOW_RST;
            earliest_time_reg <= '0;
            std_offset_reg    <= '0;
            pred_found_reg    <= 1'b0;
            succ_found_reg    <= 1'b0;
            vic_found_reg     <= 1'b0;
            free_found_reg    <= 1'b0;
            pmatch_reg        <= 1'b0;
            smatch_reg        <= 1'b0;
        end else begin
            state_reg         <= state_next;
            cnt_reg           <= cnt_next;
            pipe_vld_reg      <= pipe_vld_next;
            touch_reg         <= touch_next;
            valid_reg         <= valid_next;
            out_valid_reg     <= out_valid_next;
            merge_window_reg  <= merge_window_next;
            earliest_time_reg <= earliest_time_next;
            std_offset_reg    <= std_offset_next;
            pred_found_reg    <= pred_found_next;
            succ_found_reg    <= succ_found_next;
            vic_found_reg     <= vic_found_next;
            free_found_reg    <= free_found_next;
            pmatch_reg        <= pmatch_next;
            smatch_reg        <= smatch_next;
        end
    end

    always_ff @(posedge clk) begin
        pipe_idx_reg <= pipe_idx_next;
        req_reg      <= req_next;
        pred_idx_reg <= pred_idx_next;
        pred_ent_reg <= pred_ent_next;
        succ_idx_reg <= succ_idx_next;
        succ_ent_reg <= succ_ent_next;
        vic_idx_reg  <= vic_idx_next;
        vic_ent_reg  <= vic_ent_next;
        free_idx_reg <= free_idx_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second transaction taken while one is in flight");

    a_evict_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE && !pmatch_reg && !smatch_reg && !free_found_reg)
        |-> (&valid_reg))
        else $error("eviction while a free entry exists");

    a_touch_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (touch_reg == $past(touch_reg) || touch_reg == $past(touch_reg) + 32'd1))
        else $error("touch counter moved by more than one");

    a_merge_needs_both: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE && smatch_reg) |-> succ_found_reg)
        else $error("successor match without a successor");

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for the interval offset cache with LRU replacement.
`default_nettype none
module tb
    import ioc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_MERGE_WINDOW;
    logic [63:0] cfg_wdata = '0;

    interval_offset_cache_lru u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predictor state; times are kept biased so unsigned compares order them.
    logic [63:0] c_start [ENTRIES];
    logic [63:0] c_end [ENTRIES];
    logic [47:0] c_off [ENTRIES];
    logic c_dst [ENTRIES];
    logic [31:0] c_stamp [ENTRIES];
    logic c_valid [ENTRIES];
    logic [31:0] c_touch;
    logic [39:0] win_reg;
    logic [63:0] lb_reg;
    logic [47:0] std_reg;

    out_t expected_q[$];
    int n_errors = 0;
    int n_checked = 0;
    int n_hits = 0;
    int n_merges = 0;
    int n_evicts = 0;
    int idle_cycles = 0;
    bit no_idle = 1'b0;

    // Times used by updates, so lookups can aim at recorded regions.
    logic [63:0] recent_times[$];

    function automatic int find_pred(input logic [63:0] t);
        int best;
        best = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (c_valid[i] && c_start[i] <= t && (best < 0 || c_start[i] > c_start[best]))
                best = i;
        return best;
    endfunction

    function automatic int find_succ(input logic [63:0] t);
        int best;
        best = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (c_valid[i] && c_start[i] > t && (best < 0 || c_start[i] < c_start[best]))
                best = i;
        return best;
    endfunction

    task automatic predict_offset(input in_t item, output out_t res);
        logic [63:0] t;
        int p;
        int s;
        int slot;
        bit done;
        t = item.time_point ^ SIGN_BIT;
        res = '0;
        done = 1'b0;
        if (item.func == FN_LOOKUP) begin
            if (t < lb_reg) begin
                res.status = ST_BEFORE;
                res.offset_out = std_reg;
                return;
            end
            c_touch++;
            p = find_pred(t);
            res.status = ST_MISS;
            if (p >= 0 && t <= c_end[p]) begin
                c_stamp[p] = c_touch;
                res.status = ST_HIT;
                res.offset_out = c_off[p];
                res.dst_out = c_dst[p];
                n_hits++;
            end
            return;
        end
        res.status = ST_UPDATE;
        c_touch++;
        p = find_pred(t);
        if (p >= 0 && t <= c_end[p]) begin
            c_stamp[p] = c_touch;
            return;
        end
        if (p >= 0 && c_off[p] == item.offset_in && c_dst[p] == item.dst_in
            && t - c_end[p] <= {24'd0, win_reg}) begin
            c_end[p] = t;
            c_stamp[p] = c_touch;
            done = 1'b1;
            n_merges++;
        end
        s = find_succ(t);
        if (s >= 0 && c_off[s] == item.offset_in && c_dst[s] == item.dst_in
            && c_start[s] - t <= {24'd0, win_reg}) begin
            n_merges++;
            if (done) begin
                c_end[p] = c_end[s];
                c_stamp[p] = c_touch;
                c_valid[s] = 1'b0;
            end else begin
                c_start[s] = t;
                c_stamp[s] = c_touch;
                done = 1'b1;
            end
        end
        if (!done) begin
            slot = -1;
            for (int i = 0; i < ENTRIES; i++)
                if (!c_valid[i] && slot < 0)
                    slot = i;
            if (slot < 0) begin
                n_evicts++;
                for (int i = 0; i < ENTRIES; i++)
                    if (slot < 0 || c_stamp[i] < c_stamp[slot]
                        || (c_stamp[i] == c_stamp[slot] && c_start[i] < c_start[slot]))
                        slot = i;
            end
            c_start[slot] = t;
            c_end[slot] = t;
            c_off[slot] = item.offset_in;
            c_dst[slot] = item.dst_in;
            c_stamp[slot] = c_touch;
            c_valid[slot] = 1'b1;
        end
    endtask

    // Result checking and random output stalls.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result %p", $time, out_data);
            end else begin
                out_t exp_res;
                exp_res = expected_q.pop_front();
                n_checked++;
                if (out_data.status !== exp_res.status) begin
                    n_errors++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_res.status, out_data.status);
                end
                if (out_data.offset_out !== exp_res.offset_out) begin
                    n_errors++;
                    $display("%0t: offset_out expected %h actual %h", $time,
                             exp_res.offset_out, out_data.offset_out);
                end
                if (out_data.dst_out !== exp_res.dst_out) begin
                    n_errors++;
                    $display("%0t: dst_out expected %0b actual %0b", $time,
                             exp_res.dst_out, out_data.dst_out);
                end
            end
        end
    end

    int stall_left = 0;
    always @(posedge clk)
    begin
        if (no_idle) begin
            out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 19) - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Watchdog: cycles with no transaction on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MERGE_WINDOW: win_reg = val[39:0];
            CFG_EARLIEST_TIME: lb_reg = val ^ SIGN_BIT;
            default: std_reg = val[47:0];
        endcase
    endtask

    // Waits for all outstanding results, then for the block to go quiet.
    task automatic drain();
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Sends one transaction; a typed expectation overrides the predictor.
    // Ready is sampled at the falling edge, where it is stable until the next rising edge.
    task automatic send_item(input in_t item, input bit has_exp, input out_t exp_res);
        out_t pred;
        if (!no_idle && $urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 19)) @(posedge clk);
        in_valid <= 1'b1;
        in_data <= item;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        predict_offset(item, pred);
        if (item.func == FN_UPDATE)
            recent_times.push_back(item.time_point);
        if (recent_times.size() > 200)
            void'(recent_times.pop_front());
        expected_q.push_back(has_exp ? exp_res : pred);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    typedef struct {
        in_t item;
        bit has_exp;
        out_t exp_res;
    } stim_row_t;

    localparam logic [63:0] T_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] T_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [47:0] O_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] O_MIN = 48'h8000_0000_0000;

    stim_row_t directed_rows[$];

    function automatic stim_row_t row(input logic fn, input logic [63:0] t,
                                      input logic [47:0] off, input logic d,
                                      input bit he, input logic [1:0] st,
                                      input logic [47:0] eo, input logic ed);
        stim_row_t r;
        r.item = '{func: fn, time_point: t, offset_in: off, dst_in: d};
        r.has_exp = he;
        r.exp_res = '{status: st, offset_out: eo, dst_out: ed};
        return r;
    endfunction

    task automatic random_phase(input int count, input int spread);
        in_t item;
        logic [63:0] base;
        for (int k = 0; k < count; k++) begin
            item.func = $urandom_range(0, 1) ? FN_UPDATE : FN_LOOKUP;
            item.dst_in = 1'($urandom_range(0, 1));
            // Mostly one of three offsets, so matching neighbors are common.
            item.offset_in = $urandom_range(0, 9) == 0 ? 48'(rand64())
                                                       : 48'(3600 * $urandom_range(0, 2));
            case ($urandom_range(0, 9))
                0: item.time_point = rand64();
                1, 2: item.time_point = $urandom_range(0, 1) ? T_MIN + $urandom_range(0, 3)
                                                             : T_MAX - $urandom_range(0, 3);
                default:
                    if (recent_times.size() != 0 && $urandom_range(0, 1)) begin
                        base = recent_times[$urandom_range(0, recent_times.size() - 1)];
                        item.time_point = base + 64'($signed($urandom_range(0, 2 * spread)
                                                             - spread));
                    end else begin
                        item.time_point = 64'($urandom_range(0, 64 * spread));
                    end
            endcase
            send_item(item, 1'b0, '0);
        end
    endtask

    initial
    begin
        stim_row_t r;
        for (int i = 0; i < ENTRIES; i++)
            c_valid[i] = 1'b0;
        c_touch = '0;
        win_reg = MERGE_WINDOW_RST;
        lb_reg = SIGN_BIT;
        std_reg = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under reset settings, with a lower bound written later.
        directed_rows.push_back(row(FN_LOOKUP, 64'd0, '0, 0, 1, ST_MISS, '0, 0));
        directed_rows.push_back(row(FN_LOOKUP, T_MIN, '0, 0, 1, ST_BEFORE, '0, 0));
        directed_rows.push_back(row(FN_LOOKUP, T_MAX, '0, 0, 1, ST_MISS, '0, 0));
        // Update before lower bound is not filtered.
        directed_rows.push_back(row(FN_UPDATE, T_MIN, O_MIN, 1, 1, ST_UPDATE, '0, 0));
        directed_rows.push_back(row(FN_UPDATE, T_MAX, O_MAX, 1, 1, ST_UPDATE, '0, 0));
        directed_rows.push_back(row(FN_LOOKUP, T_MAX, '0, 0, 1, ST_HIT, O_MAX, 1));
        directed_rows.push_back(row(FN_UPDATE, 64'd1000, 48'd3600, 0, 1, ST_UPDATE, '0, 0));
        directed_rows.push_back(row(FN_UPDATE, 64'd1000 + 604800, 48'd3600, 0, 0, 0, '0, 0));
        directed_rows.push_back(row(FN_LOOKUP, 64'd5000, '0, 0, 1, ST_HIT, 48'd3600, 0));
        directed_rows.push_back(row(FN_UPDATE, 64'd1000 + 2 * 604800 + 1, 48'd3600, 0,
                                    0, 0, '0, 0));
        directed_rows.push_back(row(FN_UPDATE, 64'd1000 + 3 * 604800 + 1, 48'd3600, 0,
                                    0, 0, '0, 0));
        // An update inside an interval grown by an earlier merge only refreshes its stamp.
        directed_rows.push_back(row(FN_UPDATE, 64'd1000 + 2 * 604800 + 604800 / 2, 48'd3600, 0,
                                    0, 0, '0, 0));
        directed_rows.push_back(row(FN_LOOKUP, 64'd1000 + 3 * 604800, '0, 0, 0, 0, '0, 0));
        // Covered update with a different offset keeps the entry's offset and flag.
        directed_rows.push_back(row(FN_UPDATE, 64'd2000, 48'd7200, 1, 1, ST_UPDATE, '0, 0));
        directed_rows.push_back(row(FN_LOOKUP, 64'd2000, '0, 0, 1, ST_HIT, 48'd3600, 0));
        directed_rows.push_back(row(FN_UPDATE, 64'd1000 - 10, 48'd3600, 0, 0, 0, '0, 0));
        directed_rows.push_back(row(FN_LOOKUP, 64'd990, '0, 0, 1, ST_HIT, 48'd3600, 0));
        directed_rows.push_back(row(FN_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, '0, 0, 1, ST_BEFORE,
                                    '0, 0));
        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            send_item(r.item, r.has_exp, r.exp_res);
        end
        drain();

        // Extremes of the registers; the lookup rows have typed results.
        write_reg(CFG_EARLIEST_TIME, T_MAX);
        write_reg(CFG_STANDARD_OFFSET, {16'd0, O_MIN});
        write_reg(CFG_MERGE_WINDOW, 64'hFF_FFFF_FFFF);
        send_item('{func: FN_LOOKUP, time_point: 64'd5, offset_in: '1, dst_in: 1}, 1,
                  '{status: ST_BEFORE, offset_out: O_MIN, dst_out: 0});
        send_item('{func: FN_LOOKUP, time_point: T_MAX, offset_in: '0, dst_in: 0}, 1,
                  '{status: ST_HIT, offset_out: O_MAX, dst_out: 1});
        drain();
        write_reg(CFG_EARLIEST_TIME, T_MIN);
        write_reg(CFG_STANDARD_OFFSET, {16'hFFFF, O_MAX});
        write_reg(CFG_MERGE_WINDOW, 64'd0);
        random_phase(400, 2000);
        drain();

        write_reg(CFG_MERGE_WINDOW, 64'd604800);
        write_reg(CFG_EARLIEST_TIME, 64'd0);
        write_reg(CFG_STANDARD_OFFSET, 64'd3600);
        random_phase(500, 400000);
        drain();

        write_reg(CFG_MERGE_WINDOW, 64'hFF_FFFF_FFFF);
        write_reg(CFG_EARLIEST_TIME, rand64());
        write_reg(CFG_STANDARD_OFFSET, rand64());
        random_phase(500, 3000000);
        drain();

        write_reg(CFG_MERGE_WINDOW, 64'd50);
        write_reg(CFG_EARLIEST_TIME, T_MIN + 2);
        no_idle = 1'b1;
        random_phase(400, 100);
        drain();

        $display("Checked %0d results: %0d hits, %0d merge steps, %0d evictions.",
                 n_checked, n_hits, n_merges, n_evicts);
        $display("Register extremes, covered updates and both time limits were exercised.");
        if (n_errors == 0 && expected_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
